// File: rtl/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// shared types, constants and helpers of the bilinear texture sampler
// ----------------------------------------------------------------------------
package tbs_pkg;

	localparam int CH_BITS    = 16;
	localparam int TEXEL_BITS = 4 * CH_BITS;
	localparam int FRAC_BITS  = 16;
	localparam int COORD_BITS = 18;
	localparam int FIX_BITS   = FRAC_BITS + 1;
	localparam int IDX_BITS   = 10;
	localparam int SIZE_BITS  = IDX_BITS + 1;
	localparam int REG_BITS   = 7;
	localparam int PROD_BITS  = FIX_BITS + SIZE_BITS;

	localparam logic [FIX_BITS-1:0] ONE_FIX  = FIX_BITS'(1) << FRAC_BITS;
	localparam logic [FIX_BITS-1:0] ZERO_FIX = '0;
	localparam logic [SIZE_BITS-1:0] MIN_SIZE = SIZE_BITS'(2);

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_READ     = 2'd1,
		OP_NEAREST  = 2'd2,
		OP_BILINEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_WRITE,
		ST_FETCH,
		ST_LATCH,
		ST_LERP,
		ST_DONE
	} state_t;

	// one decoded job handed from the front to the back
	typedef struct packed {
		op_t                   op;
		logic                  err;
		logic [IDX_BITS-1:0]   ix;
		logic [IDX_BITS-1:0]   iy;
		logic [FIX_BITS-1:0]   fu;
		logic [FIX_BITS-1:0]   fv;
		logic [TEXEL_BITS-1:0] data;
	} job_t;

	// size register as used: below two acts as two, above the maximum as the maximum
	function automatic logic [SIZE_BITS-1:0] eff_size(input logic [REG_BITS-1:0] r,
			input logic [SIZE_BITS-1:0] m);
		logic [SIZE_BITS-1:0] rv;
		rv = SIZE_BITS'(r);
		if (rv < MIN_SIZE) return MIN_SIZE;
		if (rv > m) return m;
		return rv;
	endfunction

	// signed q1.16 coordinate clamped to 0..1
	function automatic logic [FIX_BITS-1:0] clamp_coord(input logic [COORD_BITS-1:0] c);
		if (c[COORD_BITS-1]) return ZERO_FIX;
		if (c[FIX_BITS-1:0] > ONE_FIX) return ONE_FIX;
		return c[FIX_BITS-1:0];
	endfunction

endpackage

// File: rtl/tbs_if.sv
// ----------------------------------------------------------------------------
// tbs interfaces
// request, result and configuration channels of the texture sampler
// ----------------------------------------------------------------------------
interface tbs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [5:0]  texel_x;
	logic [5:0]  texel_y;
	logic signed [17:0] coord_u;
	logic signed [17:0] coord_v;
	logic [15:0] in_red;
	logic [15:0] in_green;
	logic [15:0] in_blue;
	logic [15:0] in_alpha;

	modport source (output valid, op, texel_x, texel_y, coord_u, coord_v,
		in_red, in_green, in_blue, in_alpha, input ready);
	modport sink (input valid, op, texel_x, texel_y, coord_u, coord_v,
		in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface tbs_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;
	logic [15:0] out_alpha;
	logic        index_error;

	modport source (output valid, out_red, out_green, out_blue, out_alpha,
		index_error, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha,
		index_error, output ready);
endinterface

interface tbs_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [6:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/tbs_front.sv
// ----------------------------------------------------------------------------
// tbs_front
// accepts items, scales coordinates and classifies them into jobs
// ----------------------------------------------------------------------------
module tbs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tbs_pkg::SIZE_BITS-1:0] w,
	input  logic [tbs_pkg::SIZE_BITS-1:0] h,
	tbs_req_if.sink                       req,
	output logic                          push,
	output tbs_pkg::job_t                 push_job,
	input  logic                          full
);

	logic                             valid_s1;
	tbs_pkg::op_t                     op_s1;
	logic [5:0]                       tx_s1;
	logic [5:0]                       ty_s1;
	logic [tbs_pkg::TEXEL_BITS-1:0]   data_s1;
	logic [tbs_pkg::PROD_BITS-1:0]    pu_s1;
	logic [tbs_pkg::PROD_BITS-1:0]    pv_s1;

	logic                             in_range;
	logic                             drop;
	logic                             adv;
	logic [tbs_pkg::IDX_BITS-1:0]     ixn;
	logic [tbs_pkg::IDX_BITS-1:0]     iyn;
	logic [tbs_pkg::IDX_BITS-1:0]     ixb;
	logic [tbs_pkg::IDX_BITS-1:0]     iyb;
	logic [tbs_pkg::PROD_BITS-1:0]    du;
	logic [tbs_pkg::PROD_BITS-1:0]    dv;

	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// scale stage: clamped coordinate times (size - 1)
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= tbs_pkg::op_t'(req.op);
			tx_s1   <= req.texel_x;
			ty_s1   <= req.texel_y;
			data_s1 <= {req.in_alpha, req.in_blue, req.in_green, req.in_red};
			pu_s1   <= tbs_pkg::PROD_BITS'(tbs_pkg::clamp_coord(req.coord_u))
				* tbs_pkg::PROD_BITS'(w - tbs_pkg::SIZE_BITS'(1));
			pv_s1   <= tbs_pkg::PROD_BITS'(tbs_pkg::clamp_coord(req.coord_v))
				* tbs_pkg::PROD_BITS'(h - tbs_pkg::SIZE_BITS'(1));
		end
	end

	always_comb begin
		in_range = (tbs_pkg::SIZE_BITS'(tx_s1) < w) && (tbs_pkg::SIZE_BITS'(ty_s1) < h);
		drop     = (op_s1 == tbs_pkg::OP_WRITE) && !in_range;
		adv      = drop || !full;
		push     = valid_s1 && !drop && !full;

		ixn = pu_s1[tbs_pkg::FRAC_BITS +: tbs_pkg::IDX_BITS];
		iyn = pv_s1[tbs_pkg::FRAC_BITS +: tbs_pkg::IDX_BITS];
		// last column or row: step back one, fraction becomes one
		ixb = ixn;
		iyb = iyn;
		if (tbs_pkg::SIZE_BITS'(ixn) >= w - tbs_pkg::SIZE_BITS'(1)) begin
			ixb = tbs_pkg::IDX_BITS'(w - tbs_pkg::SIZE_BITS'(2));
		end
		if (tbs_pkg::SIZE_BITS'(iyn) >= h - tbs_pkg::SIZE_BITS'(1)) begin
			iyb = tbs_pkg::IDX_BITS'(h - tbs_pkg::SIZE_BITS'(2));
		end
		du = pu_s1 - (tbs_pkg::PROD_BITS'(ixb) << tbs_pkg::FRAC_BITS);
		dv = pv_s1 - (tbs_pkg::PROD_BITS'(iyb) << tbs_pkg::FRAC_BITS);

		push_job.op   = op_s1;
		push_job.err  = (op_s1 == tbs_pkg::OP_READ) && !in_range;
		push_job.data = data_s1;
		push_job.fu   = du[tbs_pkg::FIX_BITS-1:0];
		push_job.fv   = dv[tbs_pkg::FIX_BITS-1:0];
		unique case (op_s1)
			tbs_pkg::OP_WRITE, tbs_pkg::OP_READ: begin
				push_job.ix = tbs_pkg::IDX_BITS'(tx_s1);
				push_job.iy = tbs_pkg::IDX_BITS'(ty_s1);
			end
			tbs_pkg::OP_NEAREST: begin
				push_job.ix = ixn;
				push_job.iy = iyn;
			end
			default: begin
				push_job.ix = ixb;
				push_job.iy = iyb;
			end
		endcase
	end

endmodule

// File: rtl/tbs_queue.sv
// ----------------------------------------------------------------------------
// tbs_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module tbs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tbs_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output tbs_pkg::job_t head,
	output logic          empty
);

	tbs_pkg::job_t slot_q [4];
	logic [1:0]    wr_q;
	logic [1:0]    rd_q;
	logic [2:0]    cnt_q;

	assign full  = cnt_q[2];
	assign empty = (cnt_q == 3'd0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			if (push && !pop) cnt_q <= cnt_q + 3'd1;
			else if (pop && !push) cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

endmodule

// File: rtl/tbs_back.sv
// ----------------------------------------------------------------------------
// tbs_back
// texel memory, fetch sequencer, shared lerp unit and result register
// ----------------------------------------------------------------------------
module tbs_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tbs_pkg::SIZE_BITS-1:0] w,
	input  logic                          empty,
	input  tbs_pkg::job_t                 head,
	output logic                          pop,
	tbs_rsp_if.source                     rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = tbs_pkg::CH_BITS;
	localparam int TB    = tbs_pkg::TEXEL_BITS;
	localparam int MB    = tbs_pkg::IDX_BITS + tbs_pkg::SIZE_BITS;

	logic [TB-1:0] mem [DEPTH];
	logic [TB-1:0] rdata_q;

	tbs_pkg::state_t state_q, state_d;
	tbs_pkg::job_t   cur_q;
	logic [AW-1:0]   base_q;
	logic [1:0]      fetch_q;
	logic [3:0]      step_q;
	logic [TB-1:0]   tex_q [4];
	logic [TB-1:0]   top_q;
	logic [TB-1:0]   bot_q;
	logic [TB-1:0]   res_q;
	logic            err_q;
	logic            out_valid_q;
	logic [TB-1:0]   out_data_q;
	logic            out_err_q;

	logic            out_free;
	logic            rd_en;
	logic            wr_en;
	logic [AW:0]     rd_sum;
	logic [AW:0]     wr_sum;
	logic [MB-1:0]   base_prod;

	logic [1:0]      chan;
	logic [CB-1:0]   la;
	logic [CB-1:0]   lb;
	logic [tbs_pkg::FIX_BITS-1:0] lf;
	logic signed [CB:0]           ld;
	logic signed [CB+tbs_pkg::FIX_BITS+1:0] lp;
	logic signed [CB+tbs_pkg::FIX_BITS+2:0] ls;
	logic [CB-1:0]   lres;

	assign out_free = !out_valid_q || rsp.ready;
	assign base_prod = MB'(cur_q.iy) * MB'(w);
	assign rd_sum = (AW+1)'(base_q) + (AW+1)'(cur_q.ix) + (AW+1)'(fetch_q[0])
		+ (fetch_q[1] ? (AW+1)'(w) : '0);
	assign wr_sum = (AW+1)'(base_q) + (AW+1)'(cur_q.ix);

	// shared lerp: a + (b - a) * f, truncated
	always_comb begin
		chan = step_q[1:0];
		unique case (step_q[3:2])
			2'd0: begin
				la = tex_q[0][chan*CB +: CB];
				lb = tex_q[1][chan*CB +: CB];
				lf = cur_q.fu;
			end
			2'd1: begin
				la = tex_q[2][chan*CB +: CB];
				lb = tex_q[3][chan*CB +: CB];
				lf = cur_q.fu;
			end
			default: begin
				la = top_q[chan*CB +: CB];
				lb = bot_q[chan*CB +: CB];
				lf = cur_q.fv;
			end
		endcase
		ld   = $signed({1'b0, lb}) - $signed({1'b0, la});
		lp   = ld * $signed({1'b0, lf});
		ls   = $signed((CB+tbs_pkg::FIX_BITS+3)'({la, tbs_pkg::FRAC_BITS'(0)}))
			+ (CB+tbs_pkg::FIX_BITS+3)'(lp);
		lres = ls[tbs_pkg::FRAC_BITS +: CB];
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		unique case (state_q)
			tbs_pkg::ST_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = head.err ? tbs_pkg::ST_DONE : tbs_pkg::ST_BASE;
				end
			end
			tbs_pkg::ST_BASE: begin
				state_d = (cur_q.op == tbs_pkg::OP_WRITE) ? tbs_pkg::ST_WRITE
					: tbs_pkg::ST_FETCH;
			end
			tbs_pkg::ST_WRITE: begin
				wr_en   = 1'b1;
				state_d = tbs_pkg::ST_IDLE;
			end
			tbs_pkg::ST_FETCH: begin
				rd_en   = 1'b1;
				state_d = tbs_pkg::ST_LATCH;
			end
			tbs_pkg::ST_LATCH: begin
				if (cur_q.op != tbs_pkg::OP_BILINEAR) state_d = tbs_pkg::ST_DONE;
				else if (fetch_q == 2'd3) state_d = tbs_pkg::ST_LERP;
				else state_d = tbs_pkg::ST_FETCH;
			end
			tbs_pkg::ST_LERP: begin
				if (step_q == 4'd11) state_d = tbs_pkg::ST_DONE;
			end
			tbs_pkg::ST_DONE: begin
				if (out_free) state_d = tbs_pkg::ST_IDLE;
			end
			default: state_d = tbs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tbs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tbs_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_sum[AW-1:0]] <= cur_q.data;
		if (rd_en) rdata_q <= mem[rd_sum[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tbs_pkg::ST_IDLE: begin
				cur_q   <= head;
				fetch_q <= '0;
				step_q  <= '0;
				res_q   <= '0;
				err_q   <= head.err;
			end
			tbs_pkg::ST_BASE: base_q <= AW'(base_prod);
			tbs_pkg::ST_LATCH: begin
				tex_q[fetch_q] <= rdata_q;
				res_q          <= rdata_q;
				fetch_q        <= fetch_q + 2'd1;
			end
			tbs_pkg::ST_LERP: begin
				step_q <= step_q + 4'd1;
				case (step_q[3:2])
					2'd0:    top_q[chan*CB +: CB] <= lres;
					2'd1:    bot_q[chan*CB +: CB] <= lres;
					default: res_q[chan*CB +: CB] <= lres;
				endcase
			end
			tbs_pkg::ST_DONE: begin
				if (out_free) begin
					out_data_q <= res_q;
					out_err_q  <= err_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.out_red     = out_data_q[0*CB +: CB];
	assign rsp.out_green   = out_data_q[1*CB +: CB];
	assign rsp.out_blue    = out_data_q[2*CB +: CB];
	assign rsp.out_alpha   = out_data_q[3*CB +: CB];
	assign rsp.index_error = out_err_q;

endmodule

// File: rtl/texture_2d_bilinear_sampler_core.sv
// ----------------------------------------------------------------------------
// texture_2d_bilinear_sampler_core
// rgba texel store with read, nearest and bilinear clamp-to-edge sampling
// ----------------------------------------------------------------------------
// usage
//   req: one item per handshake; op selects write, read, nearest or bilinear
//   rsp: one item for every read or sample, none for a write
//   cfg: width/height in use (index 0/1), written while the block is idle;
//        always ready, sizes clamped to 2..MAX at the write
// sequencing
//   the front registers the coordinate scaling, then a four-deep job queue
//   feeds the back sequencer, which owns a single-port texel memory
//   write: pop, base, write; read/nearest: pop, base, fetch, latch, done;
//   bilinear: pop, base, four fetches of fetch and latch, twelve steps of
//   one shared lerp multiplier, then the hand-off to the result register
//   an out-of-range read skips the memory and returns zeros with index_error
// reset
//   clears the pipeline, queue and sequencer; sizes return to 64 by 64;
//   the texel memory is not cleared, unwritten texels read as unknown
// stall
//   a held result waits in the output register; the queue keeps taking items
//   until it fills, then req.ready drops
// ----------------------------------------------------------------------------
module texture_2d_bilinear_sampler_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	tbs_req_if.sink   req,
	tbs_rsp_if.source rsp,
	tbs_cfg_if.sink   cfg
);

	// effective sizes, already clamped
	logic [tbs_pkg::SIZE_BITS-1:0] w_q;
	logic [tbs_pkg::SIZE_BITS-1:0] h_q;

	// front to queue
	logic          push;
	tbs_pkg::job_t push_job;
	logic          full;

	// queue to back
	logic          pop;
	logic          empty;
	tbs_pkg::job_t head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= tbs_pkg::eff_size(tbs_pkg::REG_BITS'(64),
				tbs_pkg::SIZE_BITS'(MAX_WIDTH));
			h_q <= tbs_pkg::eff_size(tbs_pkg::REG_BITS'(64),
				tbs_pkg::SIZE_BITS'(MAX_HEIGHT));
		end else if (cfg.valid) begin
			if (cfg.index == tbs_pkg::CFG_WIDTH) begin
				w_q <= tbs_pkg::eff_size(cfg.data, tbs_pkg::SIZE_BITS'(MAX_WIDTH));
			end else begin
				h_q <= tbs_pkg::eff_size(cfg.data, tbs_pkg::SIZE_BITS'(MAX_HEIGHT));
			end
		end
	end

	// accept and classify
	tbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.w        (w_q),
		.h        (h_q),
		.req      (req),
		.push     (push),
		.push_job (push_job),
		.full     (full)
	);

	// decoupling queue
	tbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// memory, fetch and filter
	tbs_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.w      (w_q),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// File: rtl/tbs_checker.sv
// ----------------------------------------------------------------------------
// tbs_checker
// port-level checks of the texture sampler
// ----------------------------------------------------------------------------
module tbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] rsp_red,
	input logic        rsp_err,
	input logic        cfg_ready
);

	// held result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// held result keeps its red channel and error flag
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_red) && $stable(rsp_err))
		else $error("result changed while stalled");

	// configuration never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	// no result right out of reset
	a_rst_quiet: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("result shown right after reset");

endmodule

bind texture_2d_bilinear_sampler_core tbs_checker u_tbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_red   (rsp.out_red),
	.rsp_err   (rsp.index_error),
	.cfg_ready (cfg.ready)
);
